[rtl/core/ssvf_pkg.sv]
// ----------------------------------------------------------------------------
// ssvf_pkg
// Shared types and constants for the seven-segment value formatter.
// ----------------------------------------------------------------------------
package ssvf_pkg;

    typedef enum logic [1:0] {
        OP_SPEED   = 2'd0,
        OP_BATTERY = 2'd1,
        OP_TEMP    = 2'd2,
        OP_HOLD    = 2'd3
    } t_opcode;

    // decimal digits of the saturated value, plus the full-charge flag
    typedef struct packed {
        logic [3:0] ones;
        logic [3:0] tens;
        logic [3:0] hund;
        logic [3:0] thou;
        logic       full;
    } t_digits;

    localparam int unsigned SAT_W = 14;

    localparam logic [SAT_W-1:0] SPEED_MAX   = 14'd9999;
    localparam logic [SAT_W-1:0] BATTERY_MAX = 14'd1000;
    localparam logic [SAT_W-1:0] TEMP_MAX    = 14'd999;

    localparam logic [7:0] CODE_BLANK = 8'h0F;
    localparam logic [7:0] CODE_POINT = 8'h80;
    localparam logic [7:0] DIGIT_MAX  = 8'd9;

    // reciprocal multipliers, exact floor for values below 10000
    localparam logic [12:0] RECIP_10   = 13'd6554;   // 2^16 / 10
    localparam logic [13:0] RECIP_100  = 14'd10486;  // 2^20 / 100
    localparam logic [14:0] RECIP_1000 = 15'd16778;  // 2^24 / 1000

endpackage

[rtl/core/ssvf_digits.sv]
// ----------------------------------------------------------------------------
// ssvf_digits
// Saturates the value for the selected group and splits it into decimal
// digits with constant reciprocal multiplies.
// ----------------------------------------------------------------------------
module ssvf_digits (
    input  ssvf_pkg::t_opcode i_opcode,
    input  logic [15:0]       i_value,
    output ssvf_pkg::t_digits o_digits
);

    logic [ssvf_pkg::SAT_W-1:0] sat;
    logic [26:0]                p10;
    logic [27:0]                p100;
    logic [28:0]                p1000;
    logic [9:0]                 q10;
    logic [6:0]                 q100;
    logic [3:0]                 q1000;
    logic [13:0]                rem_ones;
    logic [9:0]                 rem_tens;
    logic [6:0]                 rem_hund;
    logic                       full;

    always_comb begin
        full = 1'b0;
        case (i_opcode)
            ssvf_pkg::OP_SPEED: begin
                sat = (i_value > 16'(ssvf_pkg::SPEED_MAX)) ? ssvf_pkg::SPEED_MAX
                                                           : i_value[13:0];
            end
            ssvf_pkg::OP_BATTERY: begin
                full = (i_value >= 16'(ssvf_pkg::BATTERY_MAX));
                sat  = full ? ssvf_pkg::BATTERY_MAX : i_value[13:0];
            end
            ssvf_pkg::OP_TEMP: begin
                sat = (i_value > 16'(ssvf_pkg::TEMP_MAX)) ? ssvf_pkg::TEMP_MAX
                                                          : i_value[13:0];
            end
            default: begin
                sat = '0;
            end
        endcase
    end

    // three independent quotients, no multiply feeds another
    assign p10   = 27'(sat) * 27'(ssvf_pkg::RECIP_10);
    assign p100  = 28'(sat) * 28'(ssvf_pkg::RECIP_100);
    assign p1000 = 29'(sat) * 29'(ssvf_pkg::RECIP_1000);

    assign q10   = p10[25:16];
    assign q100  = p100[26:20];
    assign q1000 = p1000[27:24];

    assign rem_ones = sat - 14'(q10) * 14'd10;
    assign rem_tens = q10 - 10'(q100) * 10'd10;
    assign rem_hund = q100 - 7'(q1000) * 7'd10;

    assign o_digits.ones = rem_ones[3:0];
    assign o_digits.tens = rem_tens[3:0];
    assign o_digits.hund = rem_hund[3:0];
    assign o_digits.thou = q1000;
    assign o_digits.full = full;

endmodule

[rtl/core/ssvf_store.sv]
// ----------------------------------------------------------------------------
// ssvf_store
// Eight-digit display buffer; it doubles as the result register and only
// changes when a beat moves into it.
// ----------------------------------------------------------------------------
module ssvf_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ssvf_pkg::t_opcode i_opcode,
    input  ssvf_pkg::t_digits i_digits,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_digit [8]
);

    logic [7:0] r_store [8];
    logic [7:0] n_store [8];
    logic       r_out_valid;
    logic       advance;

    function automatic logic [7:0] code(input logic [3:0] d);
        code = {4'h0, d};
    endfunction

    assign o_ready = !r_out_valid || i_out_ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        n_store = r_store;
        case (i_opcode)
            ssvf_pkg::OP_SPEED: begin
                n_store[0] = code(i_digits.tens);
                n_store[1] = code(i_digits.hund);
                n_store[2] = code(i_digits.thou);
                if (i_digits.thou == 4'd0) begin
                    n_store[2] = ssvf_pkg::CODE_BLANK;
                    if (i_digits.hund == 4'd0) begin
                        n_store[1] = ssvf_pkg::CODE_BLANK;
                    end
                end
            end
            ssvf_pkg::OP_BATTERY: begin
                if (i_digits.full) begin
                    n_store[3] = 8'd0;
                    n_store[4] = 8'd0;
                    n_store[5] = 8'd1;
                end else begin
                    n_store[3] = code(i_digits.ones);
                    n_store[4] = code(i_digits.tens) | ssvf_pkg::CODE_POINT;
                    n_store[5] = (i_digits.hund == 4'd0) ? ssvf_pkg::CODE_BLANK
                                                         : code(i_digits.hund);
                end
            end
            ssvf_pkg::OP_TEMP: begin
                n_store[6] = code(i_digits.tens);
                n_store[7] = (i_digits.hund == 4'd0) ? ssvf_pkg::CODE_BLANK
                                                     : code(i_digits.hund);
            end
            default: begin
                n_store = r_store;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_store[i] <= 8'd0;
            end
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_store     <= n_store;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_store;

endmodule

[rtl/core/seven_segment_value_formatter.sv]
// ----------------------------------------------------------------------------
// seven_segment_value_formatter
// Rewrites one digit group of an eight-digit code-B display buffer per beat
// (none for a hold beat) and returns the whole buffer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_opcode, i_value
//  out     | output    | o_out_valid / i_out_ready | o_digit_zero .. o_digit_seven
//
//  the input register comes first, then digit split and buffer update
//  into the buffer register, which is the result register
//  one beat per cycle is sustained while the output is ready; the input register holds one more beat
//  while a result is stalled
//  synchronous active-low reset empties both stages and zeroes the buffer
// ----------------------------------------------------------------------------
module seven_segment_value_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_digit_zero,
    output logic [7:0]  o_digit_one,
    output logic [7:0]  o_digit_two,
    output logic [7:0]  o_digit_three,
    output logic [7:0]  o_digit_four,
    output logic [7:0]  o_digit_five,
    output logic [7:0]  o_digit_six,
    output logic [7:0]  o_digit_seven
);

    logic              r_in_valid;
    ssvf_pkg::t_opcode r_opcode;
    logic [15:0]       r_value;
    logic              store_ready;
    ssvf_pkg::t_digits digits;
    logic [7:0]        digit [8];

    assign o_in_ready = !r_in_valid || store_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode <= ssvf_pkg::t_opcode'(i_opcode);
            r_value  <= i_value;
        end
    end

    ssvf_digits u_digits (
        .i_opcode (r_opcode),
        .i_value  (r_value),
        .o_digits (digits)
    );

    ssvf_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_opcode    (r_opcode),
        .i_digits    (digits),
        .o_ready     (store_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_digit     (digit)
    );

    assign o_digit_zero  = digit[0];
    assign o_digit_one   = digit[1];
    assign o_digit_two   = digit[2];
    assign o_digit_three = digit[3];
    assign o_digit_four  = digit[4];
    assign o_digit_five  = digit[5];
    assign o_digit_six   = digit[6];
    assign o_digit_seven = digit[7];

`ifndef ASSERT_OFF
    // a held beat in the input register blocks input while the result stalls
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while both stages are full");

    // digits that are never blanked always hold a decimal digit
    a_plain_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_zero <= ssvf_pkg::DIGIT_MAX)
                     && (o_digit_three <= ssvf_pkg::DIGIT_MAX)
                     && (o_digit_six <= ssvf_pkg::DIGIT_MAX))
        else $error("unblankable digit out of range");

    // the buffer does not move while a result waits
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_digit_four) && $stable(o_digit_seven))
        else $error("buffer changed under a stalled result");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule
